/* src/strict_base64_decoder_assert.svh */
// ---------------------------------------------------------------------------
// strict_base64_decoder assertion macros
// Clocked checks used by the job queue; reset disables them.
// ---------------------------------------------------------------------------
`ifndef STRICT_BASE64_DECODER_ASSERT_SVH
`define STRICT_BASE64_DECODER_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset
`define SBD_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a trigger implies a result in the same cycle
`define SBD_ASSERT_IMPLY(name, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that a trigger implies a result in the next cycle
`define SBD_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* src/sbd_pkg.sv */
// ---------------------------------------------------------------------------
// sbd_pkg
// Shared types, constants and the character table of the base64 decoder.
// ---------------------------------------------------------------------------
package sbd_pkg;

    // Status codes on the end-of-payload item
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_BAD_LEN  = 3'd1;
    localparam logic [2:0] STATUS_OVER     = 3'd2;
    localparam logic [2:0] STATUS_BAD_SYM  = 3'd3;
    localparam logic [2:0] STATUS_PAD_BITS = 3'd4;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0]  PAD_CHAR        = 8'h3D;
    localparam logic [15:0] MAX_BYTES_RESET = 16'd8192;
    // Decoded bytes at the saturated quartet count (3 * 131071)
    localparam logic [18:0] BYTES_SAT       = 19'd393213;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] text_char;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic       end_mark;
    } out_item_t;

    // One unit of work for the back end: up to three bytes, then an optional status
    typedef struct packed {
        logic [1:0]  nbytes;
        logic [23:0] word;
        logic        has_status;
        logic [2:0]  status;
    } sbd_job_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    // Map one character to its sextet; valid is low outside the alphabet
    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t r;
        r.valid = 1'b1;
        r.value = 6'd0;
        if (ch >= "A" && ch <= "Z") begin
            r.value = 6'(ch - 8'h41);
        end else if (ch >= "a" && ch <= "z") begin
            r.value = 6'(ch - 8'h61 + 8'd26);
        end else if (ch >= "0" && ch <= "9") begin
            r.value = 6'(ch - 8'h30 + 8'd52);
        end else if (ch == "+") begin
            r.value = 6'd62;
        end else if (ch == "/") begin
            r.value = 6'd63;
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

/* src/sbd_front.sv */
// ---------------------------------------------------------------------------
// sbd_front
// Accepts characters, gathers quartets, checks the payload and emits jobs.
// ---------------------------------------------------------------------------
module sbd_front import sbd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        q_full,
    output logic        q_push,
    output sbd_job_t    q_job
);

    logic [15:0] max_reg;
    logic [1:0]  pos_reg, pos_next;
    logic [17:0] acc_reg, acc_next;
    logic        third_pad_reg, third_pad_next;
    logic        sym_err_reg, sym_err_next;
    logic [18:0] bytes_reg, bytes_next;

    sextet_t     sx;
    logic        is_pad;
    logic [5:0]  val;
    logic        accept;
    logic [1:0]  npad;
    logic        err_q;
    logic [18:0] bytes_inc;
    logic [18:0] decoded;
    logic [2:0]  final_status;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Classify the character
    always_comb
    begin
        sx     = sextet_of(in_data.text_char);
        is_pad = (in_data.text_char == PAD_CHAR);
        val    = sx.valid ? sx.value : 6'd0;
    end

    // Fourth-character checks and decoded size
    always_comb
    begin
        npad      = {1'b0, third_pad_reg} + {1'b0, is_pad};
        err_q     = sym_err_reg
                  | (!sx.valid && !is_pad)
                  | (!in_data.last && (is_pad || third_pad_reg))
                  | (third_pad_reg && !is_pad);
        bytes_inc = (bytes_reg == BYTES_SAT) ? bytes_reg : bytes_reg + 19'd3;
        decoded   = bytes_inc - {17'd0, npad};
        if (decoded > {3'd0, max_reg}) begin
            final_status = STATUS_OVER;
        end else if (err_q) begin
            final_status = STATUS_BAD_SYM;
        end else if (npad == 2'd2 && acc_reg[9:6] != 4'd0) begin
            final_status = STATUS_PAD_BITS;
        end else if (npad == 2'd1 && acc_reg[1:0] != 2'd0) begin
            final_status = STATUS_PAD_BITS;
        end else begin
            final_status = STATUS_OK;
        end
    end

    // Next state and job
    always_comb
    begin
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        third_pad_next = third_pad_reg;
        sym_err_next   = sym_err_reg;
        bytes_next     = bytes_reg;
        q_push         = 1'b0;
        q_job          = '0;
        if (accept) begin
            if (in_data.last && pos_reg != 2'd3) begin
                // Truncated quartet: status only, then clear
                q_push           = 1'b1;
                q_job.has_status = 1'b1;
                q_job.status     = STATUS_BAD_LEN;
                pos_next         = 2'd0;
                acc_next         = '0;
                third_pad_next   = 1'b0;
                sym_err_next     = 1'b0;
                bytes_next       = '0;
            end else if (pos_reg != 2'd3) begin
                if (pos_reg == 2'd2) begin
                    if (!sx.valid && !is_pad) sym_err_next = 1'b1;
                    third_pad_next = is_pad;
                end else begin
                    if (!sx.valid) sym_err_next = 1'b1;
                end
                acc_next = {acc_reg[11:0], val};
                pos_next = pos_reg + 2'd1;
            end else begin
                q_push         = 1'b1;
                q_job.word     = {acc_reg, val};
                q_job.nbytes   = in_data.last ? 2'd3 - npad : 2'd3;
                pos_next       = 2'd0;
                acc_next       = '0;
                third_pad_next = 1'b0;
                if (in_data.last) begin
                    q_job.has_status = 1'b1;
                    q_job.status     = final_status;
                    sym_err_next     = 1'b0;
                    bytes_next       = '0;
                end else begin
                    sym_err_next = err_q;
                    bytes_next   = bytes_inc;
                end
            end
        end
    end

    // Hold payload state and the size limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_reg       <= MAX_BYTES_RESET;
            pos_reg       <= '0;
            acc_reg       <= '0;
            third_pad_reg <= 1'b0;
            sym_err_reg   <= 1'b0;
            bytes_reg     <= '0;
        end else begin
            if (cfg_we) max_reg <= cfg_wdata;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            third_pad_reg <= third_pad_next;
            sym_err_reg   <= sym_err_next;
            bytes_reg     <= bytes_next;
        end
    end

endmodule

/* src/sbd_queue.sv */
// ---------------------------------------------------------------------------
// sbd_queue
// Small job queue that decouples character intake from result delivery.
// ---------------------------------------------------------------------------
`include "strict_base64_decoder_assert.svh"

module sbd_queue import sbd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  sbd_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output sbd_job_t head_job
);

    sbd_job_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    // Write the pushed job
    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= push_job;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)      count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push) count_reg <= count_reg - QCNT_W'(1);
        end
    end

    `SBD_ASSERT_IMPLY(a_no_push_full, push, !full || pop, "job pushed into full queue")
    `SBD_ASSERT_IMPLY(a_no_pop_empty, pop, head_valid, "job popped from empty queue")
    `SBD_ASSERT_NEXT(a_count_step, push && !pop, count_reg == $past(count_reg) + QCNT_W'(1), "queue count did not advance on push")
    `SBD_ASSERT_ALWAYS(a_count_range, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

/* src/sbd_back.sv */
// ---------------------------------------------------------------------------
// sbd_back
// Walks each job and delivers its bytes and any status through an output register.
// ---------------------------------------------------------------------------
module sbd_back import sbd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  sbd_job_t  head_job,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    sbd_job_t  job_reg;
    logic      job_valid_reg;
    logic [1:0] idx_reg;
    logic      out_valid_reg;
    out_item_t out_reg;

    logic      step;
    logic [2:0] total;
    logic      job_done;
    out_item_t item;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign step     = job_valid_reg && (!out_valid_reg || out_ready);
    assign total    = {1'b0, job_reg.nbytes} + {2'b0, job_reg.has_status};
    assign job_done = ({1'b0, idx_reg} + 3'd1) == total;
    assign pop      = head_valid && (!job_valid_reg || (step && job_done));

    // Select the result at the current index
    always_comb
    begin
        item = '0;
        if ({1'b0, idx_reg} < {1'b0, job_reg.nbytes}) begin
            item.kind = KIND_DATA;
            case (idx_reg)
                2'd0:    item.data_byte = job_reg.word[23:16];
                2'd1:    item.data_byte = job_reg.word[15:8];
                default: item.data_byte = job_reg.word[7:0];
            endcase
        end else begin
            item.kind     = KIND_STATUS;
            item.status   = job_reg.status;
            item.end_mark = 1'b1;
        end
    end

    // Advance through the job and load the next one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                job_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (step && job_done) begin
                job_valid_reg <= 1'b0;
            end else if (step) begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold job and result payloads
    always_ff @(posedge clk)
    begin
        if (pop)  job_reg <= head_job;
        if (step) out_reg <= item;
    end

endmodule

/* src/strict_base64_decoder.sv */
// ---------------------------------------------------------------------------
// strict_base64_decoder
// Canonical base64 decoder: one character in, data bytes and a status out.
//
//   channel | signals                         | transfer when
//   --------+---------------------------------+---------------------------
//   input   | in_valid, in_ready, in_data     | in_valid && in_ready
//   output  | out_valid, out_ready, out_data  | out_valid && out_ready
//   config  | cfg_we, cfg_wdata               | cfg_we (no wait)
//
// One character is taken every cycle while the four-entry job queue has room.
// Each quartet yields up to four results, sent one per cycle from the output
// register while out_ready is high, so no payload needs more result cycles
// than it has characters and, without output stalls, the input sustains one
// character per cycle. Reset clears control state and loads an 8192-byte
// limit; an output stall fills the queue and then drops in_ready.
// ---------------------------------------------------------------------------
module strict_base64_decoder import sbd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic     q_full;
    logic     q_push;
    sbd_job_t q_job;
    logic     q_pop;
    logic     q_head_valid;
    sbd_job_t q_head_job;

    // Intake and checking
    sbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // Job queue
    sbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // Result delivery
    sbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

/* sim/tb_strict_base64_decoder.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_strict_base64_decoder
// Self-checking bench for the strict base64 decoder. Characters go in over a
// valid/ready channel with random gaps. Every accepted character also runs
// through a local decoder model, which queues the data bytes and status items
// it should produce. Each result transfer is checked field by field against
// the oldest queued item. Coverage comes from directed payloads, random
// payloads (mostly well formed, some broken), several byte limits, a long
// output hold-off and a stretch at full rate with no idling on either side.
// ---------------------------------------------------------------------------
module tb_strict_base64_decoder import sbd_pkg::*; ();

    localparam int RANDOM_CHARS    = 280;
    localparam int FULL_RATE_CHARS = 60;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;

    // Decoder model state
    logic [15:0] byte_limit;
    logic [1:0]  quad_pos;
    logic [17:0] sextet_acc;
    logic        third_pad;
    logic        symbol_err;
    logic [16:0] quad_count;
    out_item_t   decoded_items[$];

    // Stimulus control
    bit          idle_on     = 1'b1;
    bit          stall_on    = 1'b1;
    int          hold_len    = 0;
    int          hold_id     = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          chars_sent  = 0;
    int          mismatches  = 0;
    logic [7:0]  text_buf[$];

    strict_base64_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Abort a hung run
    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic sextet_t char_to_sextet(input logic [7:0] ch);
        sextet_t s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (ch >= 8'h41 && ch <= 8'h5A)
            s.value = 6'(ch - 8'h41);
        else if (ch >= 8'h61 && ch <= 8'h7A)
            s.value = 6'(ch - 8'h61 + 8'd26);
        else if (ch >= 8'h30 && ch <= 8'h39)
            s.value = 6'(ch - 8'h30 + 8'd52);
        else if (ch == 8'h2B)
            s.value = 6'd62;
        else if (ch == 8'h2F)
            s.value = 6'd63;
        else
            s.valid = 1'b0;
        return s;
    endfunction

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'h41 + 8'(v);
        else if (v < 6'd52)
            return 8'h61 + 8'(v - 6'd26);
        else if (v < 6'd62)
            return 8'h30 + 8'(v - 6'd52);
        else if (v == 6'd62)
            return 8'h2B;
        return 8'h2F;
    endfunction

    function automatic out_item_t make_item(input logic kind, input logic [7:0] data,
                                            input logic [2:0] st);
        out_item_t r;
        r.kind      = kind;
        r.data_byte = data;
        r.status    = st;
        r.end_mark  = kind;
        return r;
    endfunction

    task automatic clear_payload();
        quad_pos   = 2'd0;
        sextet_acc = 18'd0;
        third_pad  = 1'b0;
        symbol_err = 1'b0;
        quad_count = 17'd0;
    endtask

    // Queue the results that one accepted character causes
    task automatic decode_char(input logic [7:0] ch, input logic is_last);
        sextet_t     sx;
        logic        is_pad;
        logic [5:0]  val;
        logic [23:0] word;
        logic [5:0]  sb;
        logic [5:0]  sc;
        int unsigned npad;
        int unsigned nbytes;
        int unsigned decoded;
        logic [2:0]  st;
        sx     = char_to_sextet(ch);
        is_pad = (ch == PAD_CHAR);
        val    = sx.valid ? sx.value : 6'd0;

        // Payload ends inside a quartet
        if (is_last && quad_pos != 2'd3)
        begin
            decoded_items.push_back(make_item(KIND_STATUS, 8'd0, STATUS_BAD_LEN));
            clear_payload();
            return;
        end

        // Gather the first three characters
        if (quad_pos != 2'd3)
        begin
            if (quad_pos < 2'd2)
            begin
                if (!sx.valid)
                    symbol_err = 1'b1;
            end
            else
            begin
                if (!sx.valid && !is_pad)
                    symbol_err = 1'b1;
                third_pad = is_pad;
            end
            sextet_acc = {sextet_acc[11:0], val};
            quad_pos   = quad_pos + 2'd1;
            return;
        end

        // Fourth character: emit the quartet
        word   = {sextet_acc, val};
        sb     = sextet_acc[11:6];
        sc     = sextet_acc[5:0];
        npad   = third_pad + is_pad;
        nbytes = is_last ? 3 - npad : 3;
        if (!sx.valid && !is_pad)
            symbol_err = 1'b1;
        if (!is_last && (is_pad || third_pad))
            symbol_err = 1'b1;
        if (third_pad && !is_pad)
            symbol_err = 1'b1;
        if (quad_count != '1)
            quad_count = quad_count + 17'd1;
        for (int i = 0; i < nbytes; i++)
            decoded_items.push_back(make_item(KIND_DATA, word[23 - 8 * i -: 8], STATUS_OK));
        quad_pos   = 2'd0;
        sextet_acc = 18'd0;
        third_pad  = 1'b0;

        if (is_last)
        begin
            decoded = quad_count * 3 - npad;
            if (decoded > byte_limit)
                st = STATUS_OVER;
            else if (symbol_err)
                st = STATUS_BAD_SYM;
            else if (npad == 2 && sb[3:0] != 4'd0)
                st = STATUS_PAD_BITS;
            else if (npad == 1 && sc[1:0] != 2'd0)
                st = STATUS_PAD_BITS;
            else
                st = STATUS_OK;
            decoded_items.push_back(make_item(KIND_STATUS, 8'd0, st));
            clear_payload();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_items.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending: kind %0d byte %02h status %0d",
                                          out_data.kind, out_data.data_byte, out_data.status));
            end
            else
            begin
                want = decoded_items.pop_front();
                if (out_data.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
                if (out_data.data_byte !== want.data_byte)
                    report_mismatch($sformatf("data_byte %02h, want %02h",
                                              out_data.data_byte, want.data_byte));
                if (out_data.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              out_data.status, want.status));
                if (out_data.end_mark !== want.end_mark)
                    report_mismatch($sformatf("end_mark %0d, want %0d",
                                              out_data.end_mark, want.end_mark));
            end
        end
    end

    // Result receiver: random stalls, plus hold-offs requested by the tests
    always @(negedge clk)
    begin
        if (hold_id != hold_seen)
        begin
            hold_seen = hold_id;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_on)
            out_ready <= ($urandom_range(0, 99) >= 36);
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Character sender and shared helpers
    // ------------------------------------------------------------------
    // Called and returns at a falling edge
    task automatic send_char(input logic [7:0] ch, input logic is_last);
        while (idle_on && $urandom_range(0, 99) < 36)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{text_char: ch, last: is_last};
        do
            @(posedge clk);
        while (!in_ready);
        decode_char(ch, is_last);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input bit end_payload);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], end_payload && (i == s.len() - 1));
    endtask

    task automatic send_buffer();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    // Stop offering and let every pending result arrive
    task automatic drain();
        in_valid <= 1'b0;
        while (decoded_items.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        byte_limit = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Build a payload: mostly canonical, some corrupted
    task automatic build_payload();
        int         nq;
        int         npad;
        int         sel;
        int         pos;
        logic [5:0] s1;
        logic [5:0] s2;
        logic [5:0] s3;
        logic [5:0] s4;
        text_buf.delete();
        nq = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
        for (int i = 0; i < 4 * (nq - 1); i++)
            text_buf.push_back(sextet_to_char(6'($urandom_range(0, 63))));
        s1   = 6'($urandom_range(0, 63));
        s2   = 6'($urandom_range(0, 63));
        s3   = 6'($urandom_range(0, 63));
        s4   = 6'($urandom_range(0, 63));
        npad = $urandom_range(0, 2);
        text_buf.push_back(sextet_to_char(s1));
        if (npad == 2)
        begin
            if ($urandom_range(0, 3) != 0)
                s2[3:0] = 4'd0;
            text_buf.push_back(sextet_to_char(s2));
            text_buf.push_back(PAD_CHAR);
            text_buf.push_back(PAD_CHAR);
        end
        else
        begin
            if (npad == 1 && $urandom_range(0, 3) != 0)
                s3[1:0] = 2'd0;
            text_buf.push_back(sextet_to_char(s2));
            text_buf.push_back(sextet_to_char(s3));
            text_buf.push_back(npad == 1 ? PAD_CHAR : sextet_to_char(s4));
        end

        // Corrupt a share of the payloads
        sel = $urandom_range(0, 99);
        pos = $urandom_range(0, text_buf.size() - 1);
        if (sel >= 65 && sel < 75)
            text_buf[pos] = 8'($urandom_range(0, 255));
        else if (sel >= 75 && sel < 83)
            text_buf[pos] = PAD_CHAR;
        else if (sel >= 83 && sel < 93)
            repeat ($urandom_range(1, 3)) void'(text_buf.pop_back());
        else if (sel >= 93)
            repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_canonical();
        send_text("+/90AZaz", 1'b1);
        send_text("TWE=", 1'b1);
    endtask

    task automatic test_pad_bits();
        send_text("TR==", 1'b1);
    endtask

    task automatic test_bad_length();
        send_text("TW", 1'b1);
    endtask

    // Padding in a middle quartet, byte extremes, '=' then a non-pad
    task automatic test_bad_symbols();
        send_text("TQ==", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h41, 1'b0);
        send_char(PAD_CHAR, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_over_limit();
        drain();
        write_limit(16'd0);
        send_text("AAAA", 1'b1);
        drain();
        write_limit(16'hFFFF);
    endtask

    // Stall the output long enough to back up the input
    task automatic test_backpressure();
        hold_len = 120;
        hold_id++;
        repeat (8) send_text("QUJD", 1'b0);
        send_text("REVG", 1'b1);
    endtask

    task automatic test_random_payloads();
        int goal;
        int blk_goal;
        goal = chars_sent + RANDOM_CHARS;
        for (int blk = 0; blk < 5; blk++)
        begin
            drain();
            case (blk)
                0: write_limit(16'($urandom_range(0, 30)));
                1: write_limit(16'd0);
                2: write_limit(16'($urandom_range(0, 65535)));
                3: write_limit(16'hFFFF);
                default: write_limit(MAX_BYTES_RESET);
            endcase
            blk_goal = chars_sent + RANDOM_CHARS / 5;
            while (chars_sent < blk_goal && chars_sent < goal)
            begin
                build_payload();
                send_buffer();
            end
        end
    endtask

    // Run one long payload at full rate on both sides, no idling
    task automatic test_full_rate();
        drain();
        idle_on  = 1'b0;
        stall_on = 1'b0;
        for (int k = 0; k < FULL_RATE_CHARS - 4; k++)
            send_char(sextet_to_char(6'($urandom_range(0, 63))), 1'b0);
        send_text("AAAA", 1'b1);
        drain();
        idle_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    initial
    begin
        int waited;
        byte_limit = MAX_BYTES_RESET;
        clear_payload();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_canonical();
        test_pad_bits();
        test_bad_length();
        test_bad_symbols();
        test_over_limit();
        test_backpressure();
        test_random_payloads();
        test_full_rate();

        // Wait out the last results
        in_valid <= 1'b0;
        waited = 0;
        while (decoded_items.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        if (decoded_items.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", decoded_items.size()));
        repeat (16) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
